[rtl/gsv_pkg.sv]
// Shared types, constants and helpers for the GIF structure validator.
package gsv_pkg;

  localparam int unsigned DimW      = 16;
  localparam int unsigned SkipW     = 10;
  localparam int unsigned PosW      = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ResDataW  = 56;

  localparam logic [DimW-1:0] MaxDimDefault    = 16'hFFFF;
  localparam logic [DimW-1:0] MaxFramesDefault = 16'hFFFF;

  localparam logic [ByteW-1:0] TrailerByte   = 8'h3B;
  localparam logic [ByteW-1:0] ExtIntroducer = 8'h21;
  localparam logic [ByteW-1:0] ImgSeparator  = 8'h2C;
  localparam logic [ByteW-1:0] SigAltNine    = 8'h39;
  localparam logic [ByteW-1:0] TableFlagMask = 8'h80;

  localparam logic [PosW-1:0] SigLen      = 4'd6;
  localparam logic [PosW-1:0] SigVerPos   = 4'd4;
  localparam logic [PosW-1:0] HdrWLoPos   = 4'd6;
  localparam logic [PosW-1:0] HdrWHiPos   = 4'd7;
  localparam logic [PosW-1:0] HdrHLoPos   = 4'd8;
  localparam logic [PosW-1:0] HdrHHiPos   = 4'd9;
  localparam logic [PosW-1:0] HdrFlagsPos = 4'd10;
  localparam logic [PosW-1:0] HdrLastPos  = 4'd12;
  localparam logic [PosW-1:0] DescLastPos = 4'd8;

  typedef enum logic [10:0] {
    PH_HEADER  = 11'b000_0000_0001,
    PH_GTABLE  = 11'b000_0000_0010,
    PH_BLOCK   = 11'b000_0000_0100,
    PH_EXT_LBL = 11'b000_0000_1000,
    PH_EXT_LEN = 11'b000_0001_0000,
    PH_EXT_DAT = 11'b000_0010_0000,
    PH_DESC    = 11'b000_0100_0000,
    PH_LTABLE  = 11'b000_1000_0000,
    PH_LZW     = 11'b001_0000_0000,
    PH_IMG_LEN = 11'b010_0000_0000,
    PH_IMG_DAT = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [0:0] {
    CFG_MAX_DIMENSION = 1'b0,
    CFG_MAX_FRAMES    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic            animated;
    logic [DimW-1:0] frames;
    logic [DimW-1:0] screen_height;
    logic [DimW-1:0] screen_width;
    logic            valid_res;
  } result_t;

  function automatic logic [ByteW-1:0] sig_byte(input logic [2:0] idx);
    logic [ByteW-1:0] r;
    r = 8'h00;
    unique case (idx)
      3'd0: r = 8'h47;
      3'd1: r = 8'h49;
      3'd2: r = 8'h46;
      3'd3: r = 8'h38;
      3'd4: r = 8'h37;
      3'd5: r = 8'h61;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [SkipW-1:0] table_size(input logic [ByteW-1:0] packed_b);
    logic [SkipW-1:0] r;
    r = SkipW'(10'd3 << ({1'b0, packed_b[2:0]} + 4'd1));
    return r;
  endfunction

endpackage

[rtl/gif_structure_validator.sv]
// Top level of the GIF structure validator: byte parser and result queue.
//
// Takes a GIF file one byte per stream beat (tlast on the final byte) and,
// on that final byte, gives one verdict: signature, screen size against
// max_dimension, block walk, frame bounds and count against max_frames.
// The whole parse step is one register update of the phase and field state,
// so a byte can be taken every cycle while the result queue is not full. The
// verdict is registered into the result queue as the final byte is taken;
// a two-entry result queue lets the parser keep taking bytes while a verdict
// waits. After a verdict all parse state clears and the next byte starts a
// new file. The user must write registers through the configuration channel
// only while no file is in flight; the block itself does not enforce this.
module gif_structure_validator #(
  parameter logic [gsv_pkg::DimW-1:0] MaxDimReset    = gsv_pkg::MaxDimDefault,
  parameter logic [gsv_pkg::DimW-1:0] MaxFramesReset = gsv_pkg::MaxFramesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gsv_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // end_of_file
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] valid_res, [16:1] screen_width, [32:17] screen_height,
  // [48:33] frames, [49] animated, [55:50] zero
  output logic [gsv_pkg::ResDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  gsv_pkg::cfg_reg_e             cfg_index_i,
  input  logic [gsv_pkg::DimW-1:0]      cfg_data_i
);

  logic [gsv_pkg::DimW-1:0] max_dim_q, max_frames_q;

  gsv_pkg::phase_e           phase_q, phase_d;
  logic [gsv_pkg::PosW-1:0]  pos_q, pos_d;
  logic [gsv_pkg::SkipW-1:0] skip_q, skip_d, skip_dec;
  logic [gsv_pkg::ByteW-1:0] flags_q, flags_d;
  logic [gsv_pkg::DimW-1:0]  scr_w_q, scr_w_d, scr_h_q, scr_h_d;
  logic [gsv_pkg::DimW-1:0]  fr_left_q, fr_left_d, fr_top_q, fr_top_d;
  logic [gsv_pkg::DimW-1:0]  fr_w_q, fr_w_d, fr_h_q, fr_h_d;
  logic [gsv_pkg::DimW-1:0]  total_q, total_d;
  logic                      failed_q, failed_d, trailer_q, trailer_d;

  logic [gsv_pkg::DimW:0]    frame_next, right_edge, bottom_edge;
  logic [gsv_pkg::ByteW-1:0] b;
  logic                      in_acc, eof_acc, res_valid;
  gsv_pkg::result_t          res_new, head_q, skid_q;
  logic                      head_valid_q, skid_valid_q, pop;

  assign b           = s_axis_tdata;
  assign in_acc      = s_axis_tvalid & s_axis_tready;
  assign eof_acc     = in_acc & s_axis_tlast;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q    <= MaxDimReset;
      max_frames_q <= MaxFramesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsv_pkg::CFG_MAX_DIMENSION: max_dim_q    <= cfg_data_i;
        gsv_pkg::CFG_MAX_FRAMES:    max_frames_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign skip_dec    = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
  assign frame_next  = {1'b0, total_q} + 1'b1;
  assign right_edge  = {1'b0, fr_left_q} + {1'b0, fr_w_q};
  assign bottom_edge = {1'b0, fr_top_q} + {1'b0, fr_h_q};

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    skip_d    = skip_q;
    flags_d   = flags_q;
    scr_w_d   = scr_w_q;
    scr_h_d   = scr_h_q;
    fr_left_d = fr_left_q;
    fr_top_d  = fr_top_q;
    fr_w_d    = fr_w_q;
    fr_h_d    = fr_h_q;
    total_d   = total_q;
    failed_d  = failed_q;
    trailer_d = trailer_q;

    if (in_acc && !failed_q && !trailer_q) begin
      unique case (phase_q)
        gsv_pkg::PH_HEADER: begin
          if (pos_q < gsv_pkg::SigLen) begin
            if (!(b == gsv_pkg::sig_byte(pos_q[2:0]) ||
                  (pos_q == gsv_pkg::SigVerPos && b == gsv_pkg::SigAltNine))) begin
              failed_d = 1'b1;
            end
          end else if (pos_q == gsv_pkg::HdrWLoPos || pos_q == gsv_pkg::HdrHLoPos ||
                       pos_q == gsv_pkg::HdrFlagsPos) begin
            flags_d = b;
          end else if (pos_q == gsv_pkg::HdrWHiPos) begin
            scr_w_d = {b, flags_q};
          end else if (pos_q == gsv_pkg::HdrHHiPos) begin
            scr_h_d = {b, flags_q};
            if (scr_w_q == '0 || scr_h_d == '0 ||
                scr_w_q > max_dim_q || scr_h_d > max_dim_q) begin
              failed_d = 1'b1;
            end
          end
          if (!failed_d) begin
            if (pos_q >= gsv_pkg::HdrLastPos) begin
              pos_d = '0;
              if ((flags_q & gsv_pkg::TableFlagMask) != '0) begin
                skip_d  = gsv_pkg::table_size(flags_q);
                phase_d = gsv_pkg::PH_GTABLE;
              end else begin
                phase_d = gsv_pkg::PH_BLOCK;
              end
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        gsv_pkg::PH_GTABLE, gsv_pkg::PH_LTABLE,
        gsv_pkg::PH_EXT_DAT, gsv_pkg::PH_IMG_DAT: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            unique case (phase_q)
              gsv_pkg::PH_GTABLE:  phase_d = gsv_pkg::PH_BLOCK;
              gsv_pkg::PH_LTABLE:  phase_d = gsv_pkg::PH_LZW;
              gsv_pkg::PH_EXT_DAT: phase_d = gsv_pkg::PH_EXT_LEN;
              default:             phase_d = gsv_pkg::PH_IMG_LEN;
            endcase
          end
        end
        gsv_pkg::PH_BLOCK: begin
          priority if (b == gsv_pkg::TrailerByte) begin
            trailer_d = 1'b1;
          end else if (b == gsv_pkg::ExtIntroducer) begin
            phase_d = gsv_pkg::PH_EXT_LBL;
          end else if (b == gsv_pkg::ImgSeparator) begin
            pos_d   = '0;
            phase_d = gsv_pkg::PH_DESC;
          end else begin
            failed_d = 1'b1;
          end
        end
        gsv_pkg::PH_EXT_LBL: phase_d = gsv_pkg::PH_EXT_LEN;
        gsv_pkg::PH_EXT_LEN: begin
          if (b == '0) begin
            phase_d = gsv_pkg::PH_BLOCK;
          end else begin
            skip_d  = gsv_pkg::SkipW'(b);
            phase_d = gsv_pkg::PH_EXT_DAT;
          end
        end
        gsv_pkg::PH_DESC: begin
          unique case (pos_q)
            4'd0: fr_left_d = {8'h00, b};
            4'd1: fr_left_d = {b, fr_left_q[7:0]};
            4'd2: fr_top_d  = {8'h00, b};
            4'd3: fr_top_d  = {b, fr_top_q[7:0]};
            4'd4: fr_w_d    = {8'h00, b};
            4'd5: fr_w_d    = {b, fr_w_q[7:0]};
            4'd6: fr_h_d    = {8'h00, b};
            4'd7: fr_h_d    = {b, fr_h_q[7:0]};
            default: flags_d = b;
          endcase
          if (pos_q < gsv_pkg::DescLastPos) begin
            pos_d = pos_q + 1'b1;
          end else begin
            pos_d = '0;
            if (fr_w_q == '0 || fr_h_q == '0 ||
                right_edge > {1'b0, scr_w_q} || bottom_edge > {1'b0, scr_h_q}) begin
              failed_d = 1'b1;
            end else if ((b & gsv_pkg::TableFlagMask) != '0) begin
              skip_d  = gsv_pkg::table_size(b);
              phase_d = gsv_pkg::PH_LTABLE;
            end else begin
              phase_d = gsv_pkg::PH_LZW;
            end
          end
        end
        gsv_pkg::PH_LZW: begin
          if (b == '0) begin
            failed_d = 1'b1;
          end else begin
            phase_d = gsv_pkg::PH_IMG_LEN;
          end
        end
        gsv_pkg::PH_IMG_LEN: begin
          if (b == '0) begin
            if (frame_next > {1'b0, max_frames_q}) begin
              failed_d = 1'b1;
            end
            total_d = frame_next[gsv_pkg::DimW] ? '1 : frame_next[gsv_pkg::DimW-1:0];
            phase_d = gsv_pkg::PH_BLOCK;
          end else begin
            skip_d  = gsv_pkg::SkipW'(b);
            phase_d = gsv_pkg::PH_IMG_DAT;
          end
        end
        default: failed_d = 1'b1;
      endcase
    end

    res_valid             = trailer_d && !failed_d && total_d != '0;
    res_new.valid_res     = res_valid;
    res_new.screen_width  = scr_w_d;
    res_new.screen_height = scr_h_d;
    res_new.frames        = total_d;
    res_new.animated      = res_valid && total_d > 16'd1;

    if (eof_acc) begin
      phase_d   = gsv_pkg::PH_HEADER;
      pos_d     = '0;
      skip_d    = '0;
      flags_d   = '0;
      scr_w_d   = '0;
      scr_h_d   = '0;
      fr_left_d = '0;
      fr_top_d  = '0;
      fr_w_d    = '0;
      fr_h_d    = '0;
      total_d   = '0;
      failed_d  = 1'b0;
      trailer_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gsv_pkg::PH_HEADER;
      pos_q     <= '0;
      skip_q    <= '0;
      flags_q   <= '0;
      scr_w_q   <= '0;
      scr_h_q   <= '0;
      fr_left_q <= '0;
      fr_top_q  <= '0;
      fr_w_q    <= '0;
      fr_h_q    <= '0;
      total_q   <= '0;
      failed_q  <= 1'b0;
      trailer_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      skip_q    <= skip_d;
      flags_q   <= flags_d;
      scr_w_q   <= scr_w_d;
      scr_h_q   <= scr_h_d;
      fr_left_q <= fr_left_d;
      fr_top_q  <= fr_top_d;
      fr_w_q    <= fr_w_d;
      fr_h_q    <= fr_h_d;
      total_q   <= total_d;
      failed_q  <= failed_d;
      trailer_q <= trailer_d;
    end
  end

  assign pop           = head_valid_q & m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = head_valid_q;
  assign m_axis_tdata  = gsv_pkg::ResDataW'(head_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !head_valid_q) begin
      head_valid_q <= skid_valid_q | eof_acc;
      skid_valid_q <= skid_valid_q & eof_acc;
    end else if (eof_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !head_valid_q) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
        if (eof_acc) begin
          skid_q <= res_new;
        end
      end else if (eof_acc) begin
        head_q <= res_new;
      end
    end else if (eof_acc) begin
      skid_q <= res_new;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("result queue holds a second entry without a head");

  a_clear_after_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_acc |=> (phase_q == gsv_pkg::PH_HEADER && total_q == '0 &&
                 !failed_q && !trailer_q))
    else $error("parse state not cleared after final byte");

  a_animated_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_q && head_q.animated) |-> head_q.valid_res)
    else $error("animated flag set on an invalid verdict");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == gsv_pkg::PH_GTABLE || phase_q == gsv_pkg::PH_LTABLE ||
     phase_q == gsv_pkg::PH_EXT_DAT || phase_q == gsv_pkg::PH_IMG_DAT) |->
    skip_q != '0)
    else $error("skip phase entered with nothing to skip");
`endif

endmodule

[tb/tb_top.sv]
// Testbench for the GIF structure validator: checks each file verdict against a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned ItemTarget = 1700;
  localparam logic [47:0] SigGif87a  = "GIF87a";

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [gsv_pkg::ByteW-1:0]    s_axis_tdata  = '0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [gsv_pkg::ResDataW-1:0] m_axis_tdata;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  gsv_pkg::cfg_reg_e            cfg_index_i   = gsv_pkg::CFG_MAX_DIMENSION;
  logic [gsv_pkg::DimW-1:0]     cfg_data_i    = '0;

  gif_structure_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_file
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] valid_res, [16:1] width, [32:17] height,
                                     // [48:33] frames, [49] animated
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Parser mirror
  logic [gsv_pkg::DimW-1:0]  lim_dim      = gsv_pkg::MaxDimDefault;
  logic [gsv_pkg::DimW-1:0]  lim_frames   = gsv_pkg::MaxFramesDefault;
  gsv_pkg::phase_e           ph           = gsv_pkg::PH_HEADER;
  logic [gsv_pkg::PosW-1:0]  fpos         = '0;
  logic [gsv_pkg::SkipW-1:0] skip_left    = '0;
  logic [7:0]                flags        = '0;
  logic [15:0]               scr_w        = '0;
  logic [15:0]               scr_h        = '0;
  logic [15:0]               fr_left      = '0;
  logic [15:0]               fr_top       = '0;
  logic [15:0]               fr_w         = '0;
  logic [15:0]               fr_h         = '0;
  logic [15:0]               fr_count     = '0;
  bit                        parse_failed = 1'b0;
  bit                        trailer_hit  = 1'b0;

  gsv_pkg::result_t verdict_q[$];
  logic [7:0]       file_q[$];
  int unsigned      sent_bytes   = 0;
  int unsigned      mismatches   = 0;
  int unsigned      pending_gap  = 1;
  bit               src_idle_en  = 1'b1;
  bit               sink_idle_en = 1'b1;

  function automatic int unsigned colour_table_len(logic [7:0] pf);
    return 3 << (int'(pf[2:0]) + 1);
  endfunction

  function automatic void clear_parse();
    ph           = gsv_pkg::PH_HEADER;
    fpos         = '0;
    skip_left    = '0;
    flags        = '0;
    scr_w        = '0;
    scr_h        = '0;
    fr_left      = '0;
    fr_top       = '0;
    fr_w         = '0;
    fr_h         = '0;
    fr_count     = '0;
    parse_failed = 1'b0;
    trailer_hit  = 1'b0;
  endfunction

  function automatic void header_byte(logic [7:0] b);
    int unsigned p;
    bit          sig_ok;
    p = fpos;
    if (p < gsv_pkg::SigLen) begin
      sig_ok = (b == SigGif87a[47-8*p -: 8]) ||
               (p == gsv_pkg::SigVerPos && b == gsv_pkg::SigAltNine);
      if (!sig_ok) begin
        parse_failed = 1'b1;
        return;
      end
    end else if (p == gsv_pkg::HdrWLoPos || p == gsv_pkg::HdrHLoPos) begin
      flags = b;
    end else if (p == gsv_pkg::HdrWHiPos) begin
      scr_w = {b, flags};
    end else if (p == gsv_pkg::HdrHHiPos) begin
      scr_h = {b, flags};
      if (scr_w == 0 || scr_h == 0 || scr_w > lim_dim || scr_h > lim_dim) begin
        parse_failed = 1'b1;
        return;
      end
    end else if (p == gsv_pkg::HdrFlagsPos) begin
      flags = b;
    end
    if (p >= gsv_pkg::HdrLastPos) begin
      fpos = '0;
      if ((flags & gsv_pkg::TableFlagMask) != 0) begin
        skip_left = gsv_pkg::SkipW'(colour_table_len(flags));
        ph        = gsv_pkg::PH_GTABLE;
      end else begin
        ph = gsv_pkg::PH_BLOCK;
      end
    end else begin
      fpos = gsv_pkg::PosW'(p + 1);
    end
  endfunction

  function automatic void descriptor_byte(logic [7:0] b);
    int unsigned p;
    p = fpos;
    case (p)
      0: fr_left = {8'h00, b};
      1: fr_left[15:8] = b;
      2: fr_top = {8'h00, b};
      3: fr_top[15:8] = b;
      4: fr_w = {8'h00, b};
      5: fr_w[15:8] = b;
      6: fr_h = {8'h00, b};
      7: fr_h[15:8] = b;
      default: flags = b;
    endcase
    if (p < gsv_pkg::DescLastPos) begin
      fpos = gsv_pkg::PosW'(p + 1);
      return;
    end
    fpos = '0;
    if (fr_w == 0 || fr_h == 0 || 32'(fr_left) + 32'(fr_w) > 32'(scr_w) ||
        32'(fr_top) + 32'(fr_h) > 32'(scr_h)) begin
      parse_failed = 1'b1;
      return;
    end
    if ((flags & gsv_pkg::TableFlagMask) != 0) begin
      skip_left = gsv_pkg::SkipW'(colour_table_len(flags));
      ph        = gsv_pkg::PH_LTABLE;
    end else begin
      ph = gsv_pkg::PH_LZW;
    end
  endfunction

  function automatic void count_frame();
    int unsigned n;
    n = 32'(fr_count) + 1;
    if (n > lim_frames) parse_failed = 1'b1;
    fr_count = (n > 32'hFFFF) ? 16'hFFFF : 16'(n);
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (ph)
      gsv_pkg::PH_HEADER: header_byte(b);
      gsv_pkg::PH_GTABLE, gsv_pkg::PH_LTABLE,
      gsv_pkg::PH_EXT_DAT, gsv_pkg::PH_IMG_DAT: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          case (ph)
            gsv_pkg::PH_GTABLE:  ph = gsv_pkg::PH_BLOCK;
            gsv_pkg::PH_LTABLE:  ph = gsv_pkg::PH_LZW;
            gsv_pkg::PH_EXT_DAT: ph = gsv_pkg::PH_EXT_LEN;
            default:             ph = gsv_pkg::PH_IMG_LEN;
          endcase
        end
      end
      gsv_pkg::PH_BLOCK: begin
        if (b == gsv_pkg::TrailerByte) trailer_hit = 1'b1;
        else if (b == gsv_pkg::ExtIntroducer) ph = gsv_pkg::PH_EXT_LBL;
        else if (b == gsv_pkg::ImgSeparator) begin
          fpos = '0;
          ph   = gsv_pkg::PH_DESC;
        end else parse_failed = 1'b1;
      end
      gsv_pkg::PH_EXT_LBL: ph = gsv_pkg::PH_EXT_LEN;
      gsv_pkg::PH_EXT_LEN: begin
        if (b == 0) ph = gsv_pkg::PH_BLOCK;
        else begin
          skip_left = gsv_pkg::SkipW'(b);
          ph        = gsv_pkg::PH_EXT_DAT;
        end
      end
      gsv_pkg::PH_DESC: descriptor_byte(b);
      gsv_pkg::PH_LZW: begin
        if (b == 0) parse_failed = 1'b1;
        else ph = gsv_pkg::PH_IMG_LEN;
      end
      gsv_pkg::PH_IMG_LEN: begin
        if (b == 0) begin
          count_frame();
          ph = gsv_pkg::PH_BLOCK;
        end else begin
          skip_left = gsv_pkg::SkipW'(b);
          ph        = gsv_pkg::PH_IMG_DAT;
        end
      end
      default: parse_failed = 1'b1;
    endcase
  endfunction

  function automatic void predict_verdict(logic [7:0] b, bit eof);
    gsv_pkg::result_t r;
    bit               ok;
    if (!parse_failed && !trailer_hit) begin
      parse_byte(b);
    end
    if (!eof) return;
    ok              = trailer_hit && !parse_failed && fr_count > 0;
    r.valid_res     = ok;
    r.screen_width  = scr_w;
    r.screen_height = scr_h;
    r.frames        = fr_count;
    r.animated      = ok && fr_count > 1;
    verdict_q.push_back(r);
    clear_parse();
  endfunction

  // File builders
  function automatic void put_random(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void put16(int unsigned v);
    file_q.push_back(8'(v));
    file_q.push_back(8'(v >> 8));
  endfunction

  function automatic logic [7:0] rand_flags();
    logic [7:0] f;
    f = 8'($urandom);
    f[2:0] = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
    return f;
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return 65535;
      2:       return $urandom_range(1, 65535);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic void put_header(bit v89, int unsigned w, int unsigned h,
                                     logic [7:0] hflags);
    int i;
    for (i = 0; i < gsv_pkg::SigLen; i++) begin
      file_q.push_back((i == gsv_pkg::SigVerPos && v89) ? gsv_pkg::SigAltNine
                                                         : SigGif87a[47-8*i -: 8]);
    end
    put16(w);
    put16(h);
    file_q.push_back(hflags);
    put_random(2);
    if ((hflags & gsv_pkg::TableFlagMask) != 0) put_random(colour_table_len(hflags));
  endfunction

  function automatic void put_chain(int unsigned max_n, int unsigned max_len);
    int unsigned len;
    repeat ($urandom_range(0, max_n)) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, max_len);
      file_q.push_back(8'(len));
      put_random(len);
    end
    file_q.push_back(8'h00);
  endfunction

  function automatic void put_ext();
    file_q.push_back(gsv_pkg::ExtIntroducer);
    put_random(1);
    put_chain(2, 8);
  endfunction

  function automatic void put_frame(int unsigned l, int unsigned t, int unsigned w,
                                    int unsigned h, logic [7:0] ff, logic [7:0] lzw,
                                    int unsigned max_sub);
    file_q.push_back(gsv_pkg::ImgSeparator);
    put16(l);
    put16(t);
    put16(w);
    put16(h);
    file_q.push_back(ff);
    if ((ff & gsv_pkg::TableFlagMask) != 0) put_random(colour_table_len(ff));
    file_q.push_back(lzw);
    put_chain(max_sub, 12);
  endfunction

  function automatic void put_rand_frame(int unsigned sw, int unsigned sh);
    int unsigned w;
    int unsigned h;
    w = $urandom_range(1, sw);
    h = $urandom_range(1, sh);
    put_frame($urandom_range(0, sw - w), $urandom_range(0, sh - h), w, h, rand_flags(),
              8'($urandom_range(1, 255)), 3);
  endfunction

  function automatic void put_rand_gif(int unsigned sw, int unsigned sh, int unsigned n);
    put_header($urandom_range(0, 1), sw, sh, rand_flags());
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) put_ext();
      put_rand_frame(sw, sh);
    end
    if ($urandom_range(0, 3) == 0) put_ext();
    file_q.push_back(gsv_pkg::TrailerByte);
  endfunction

  function automatic void truncate_file(int unsigned keep);
    while (file_q.size() > keep) void'(file_q.pop_back());
  endfunction

  // Request driver
  task automatic send_byte(logic [7:0] b, bit eof);
    repeat (pending_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_verdict(b, eof);
    sent_bytes++;
    pending_gap = src_idle_en ? $urandom_range(0, 14) : 0;
    if (pending_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic src_halt();
    if (pending_gap == 0) begin
      s_axis_tvalid <= 1'b0;
      pending_gap = 1;
    end
  endtask

  task automatic send_file();
    int unsigned n;
    int unsigned i;
    n = file_q.size();
    for (i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    file_q.delete();
  endtask

  task automatic set_limit(gsv_pkg::cfg_reg_e idx, logic [gsv_pkg::DimW-1:0] v);
    src_halt();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gsv_pkg::CFG_MAX_DIMENSION) lim_dim = v;
    else lim_frames = v;
  endtask

  task automatic one_frame_gif(int unsigned sw, int unsigned sh, int unsigned l,
                               int unsigned t, int unsigned w, int unsigned h,
                               logic [7:0] lzw);
    put_header(1'b0, sw, sh, 8'h00);
    put_frame(l, t, w, h, 8'h00, lzw, 1);
    file_q.push_back(gsv_pkg::TrailerByte);
    send_file();
  endtask

  // Result sink
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = sink_idle_en ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (gap - 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    gsv_pkg::result_t want;
    gsv_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = gsv_pkg::result_t'(m_axis_tdata[$bits(gsv_pkg::result_t)-1:0]);
      if (verdict_q.size() == 0) begin
        $error("verdict: none expected, got %h", got);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("valid_res", want.valid_res, got.valid_res);
        check_field("screen_width", want.screen_width, got.screen_width);
        check_field("screen_height", want.screen_height, got.screen_height);
        check_field("frames", want.frames, got.frames);
        check_field("animated", want.animated, got.animated);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Tests
  task automatic test_good_files();
    one_frame_gif(10, 10, 0, 0, 10, 10, 8'd2);
    put_header(1'b1, 65535, 65535, 8'h80);
    put_ext();
    put_frame(65534, 0, 1, 65535, 8'h81, 8'd8, 2);
    put_ext();
    put_frame(0, 65534, 65535, 1, 8'h00, 8'hFF, 2);
    file_q.push_back(gsv_pkg::TrailerByte);
    send_file();
    put_rand_gif(pick_dim(), pick_dim(), 3);
    send_file();
  endtask

  task automatic test_header_faults();
    put_rand_gif(20, 20, 1);
    file_q[gsv_pkg::SigVerPos] = 8'h38;
    send_file();
    put_rand_gif(20, 20, 1);
    file_q[0] = 8'h00;
    send_file();
    one_frame_gif(0, 10, 0, 0, 1, 1, 8'd2);
    one_frame_gif(10, 0, 0, 0, 1, 1, 8'd2);
    put_header(1'b1, 5, 5, 8'h00);
    file_q.push_back(gsv_pkg::TrailerByte);
    send_file();
  endtask

  task automatic test_block_faults();
    put_header(1'b0, 10, 10, 8'h00);
    file_q.push_back(8'h00);
    put_rand_frame(10, 10);
    file_q.push_back(gsv_pkg::TrailerByte);
    send_file();
    one_frame_gif(10, 10, 0, 0, 0, 5, 8'd2);
    one_frame_gif(10, 10, 0, 0, 5, 0, 8'd2);
    one_frame_gif(10, 10, 5, 0, 6, 10, 8'd2);
    one_frame_gif(10, 10, 0, 9, 10, 2, 8'd2);
    one_frame_gif(10, 10, 9, 9, 1, 1, 8'd2);
    one_frame_gif(10, 10, 0, 0, 4, 4, 8'd0);
  endtask

  task automatic test_early_end();
    file_q.push_back(SigGif87a[47:40]);
    send_file();
    put_rand_gif(30, 30, 1);
    truncate_file(18);
    send_file();
    put_header(1'b1, 8, 8, 8'h82);
    truncate_file(20);
    send_file();
    put_rand_gif(30, 30, 2);
    truncate_file(file_q.size() - 1);
    send_file();
  endtask

  task automatic test_ignored_tail();
    put_rand_gif(40, 40, 2);
    put_random(6);
    file_q.push_back(gsv_pkg::ImgSeparator);
    send_file();
  endtask

  task automatic test_limits();
    set_limit(gsv_pkg::CFG_MAX_DIMENSION, 10);
    one_frame_gif(10, 10, 0, 0, 3, 3, 8'd2);
    one_frame_gif(11, 10, 0, 0, 3, 3, 8'd2);
    one_frame_gif(10, 11, 0, 0, 3, 3, 8'd2);
    set_limit(gsv_pkg::CFG_MAX_DIMENSION, 1);
    one_frame_gif(1, 1, 0, 0, 1, 1, 8'd2);
    set_limit(gsv_pkg::CFG_MAX_DIMENSION, 16'hFFFF);
    set_limit(gsv_pkg::CFG_MAX_FRAMES, 0);
    one_frame_gif(4, 4, 0, 0, 4, 4, 8'd2);
    set_limit(gsv_pkg::CFG_MAX_FRAMES, 2);
    put_rand_gif(50, 50, 2);
    send_file();
    put_rand_gif(50, 50, 3);
    send_file();
    set_limit(gsv_pkg::CFG_MAX_FRAMES, 16'hFFFF);
  endtask

  task automatic test_random_files();
    int unsigned files;
    int unsigned sw;
    int unsigned sh;
    files = 0;
    while (files == 0 || sent_bytes < ItemTarget) begin
      if (files % 3 == 2) begin
        case ($urandom_range(0, 3))
          0: set_limit(gsv_pkg::CFG_MAX_DIMENSION, 16'hFFFF);
          1: set_limit(gsv_pkg::CFG_MAX_DIMENSION, 1);
          2: set_limit(gsv_pkg::CFG_MAX_DIMENSION, 16'($urandom_range(1, 65535)));
          default: set_limit(gsv_pkg::CFG_MAX_DIMENSION, 16'($urandom_range(200, 600)));
        endcase
        case ($urandom_range(0, 5))
          0: set_limit(gsv_pkg::CFG_MAX_FRAMES, 0);
          1: set_limit(gsv_pkg::CFG_MAX_FRAMES, 1);
          2: set_limit(gsv_pkg::CFG_MAX_FRAMES, 2);
          3: set_limit(gsv_pkg::CFG_MAX_FRAMES, 16'($urandom));
          default: set_limit(gsv_pkg::CFG_MAX_FRAMES, 16'hFFFF);
        endcase
      end
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      sw = pick_dim();
      sh = pick_dim();
      case ($urandom_range(0, 9))
        7: begin
          put_rand_gif(sw, sh, $urandom_range(1, 3));
          file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        end
        8: begin
          put_rand_gif(sw, sh, $urandom_range(1, 3));
          truncate_file($urandom_range(1, file_q.size() - 1));
        end
        9: begin
          if ($urandom_range(0, 1) == 0) put_header($urandom_range(0, 1), sw, sh, 8'h00);
          put_random($urandom_range(1, 24));
        end
        default: begin
          put_rand_gif(sw, sh, $urandom_range(0, 4));
          if ($urandom_range(0, 7) == 0) put_random($urandom_range(1, 8));
        end
      endcase
      send_file();
      files++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_good_files();
    test_header_faults();
    test_block_faults();
    test_early_end();
    test_ignored_tail();
    test_limits();
    test_random_files();
    src_halt();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
